### rtl/core/ttc_emergency_brake_check_macros.svh
// Assertion macros for the emergency brake check block.
// Each macro is empty when ASSERT_OFF is defined.
`ifndef TTC_EMERGENCY_BRAKE_CHECK_MACROS_SVH
`define TTC_EMERGENCY_BRAKE_CHECK_MACROS_SVH

`ifndef ASSERT_OFF

// Concurrent assertion of a property, clocked and held off during reset.
`define TEB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent assertion that a condition never holds.
`define TEB_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `TEB_ASSERT(lbl, clk, rstn, !(cond), msg)

`else

`define TEB_ASSERT(lbl, clk, rstn, prop, msg)
`define TEB_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

### rtl/core/teb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package teb_pkg;

    // Quarter-wave cosine table resolution.
    localparam int COS_ENTRIES = 256;
    localparam int COS_IDX_W   = $clog2(COS_ENTRIES + 1);
    localparam int COS_PROD_W  = 14 + COS_IDX_W + 1;

    // pi/2 in Q30.
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // Milliseconds per second, and the Q14 scale of the cosine.
    localparam int MS_PER_S = 1000;
    localparam int Q14_SHIFT = 14;

    // Taylor series divisors (2n-1)*2n for n = 1..7.
    localparam int TAYLOR_DIV [1:7] = '{2, 12, 30, 56, 90, 132, 182};

    typedef logic [14:0] cos_tab_t [0:COS_ENTRIES];

    // Builds the Q14 cosine table at elaboration time with the integer
    // Taylor series in Q30, clamped to [0, 1.0] and rounded to Q14.
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t           tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        for (int k = 0; k <= COS_ENTRIES; k++) begin
            x   = (64'(k) * PI_HALF_Q30) / COS_ENTRIES;
            x2  = (x * x) >> 30;
            mag = 64'd1 << 30;
            sum = 64'sd1 <<< 30;
            for (int n = 1; n <= 7; n++) begin
                mag = ((mag * x2) >> 30) / TAYLOR_DIV[n];
                if ((n & 1) != 0) begin
                    sum = sum - $signed(mag);
                end else begin
                    sum = sum + $signed(mag);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            if (sum > (64'sd1 <<< 30)) begin
                sum = 64'sd1 <<< 30;
            end
            tab[k] = 15'(($unsigned(sum) + 64'd32768) >> 16);
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ANGLE_START = 3'd0,
        REG_ANGLE_STEP  = 3'd1,
        REG_WINDOW_LOW  = 3'd2,
        REG_WINDOW_HIGH = 3'd3,
        REG_RANGE_FLOOR = 3'd4,
        REG_TTC_LIMIT   = 3'd5
    } cfg_reg_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [15:0] ANGLE_START_RST = 16'd0;
    localparam logic [11:0] ANGLE_STEP_RST  = 12'd182;
    localparam logic [15:0] WINDOW_LOW_RST  = 16'(-5461);
    localparam logic [15:0] WINDOW_HIGH_RST = 16'd5461;
    localparam logic [15:0] RANGE_FLOOR_RST = 16'd0;
    localparam logic [15:0] TTC_LIMIT_RST   = 16'd1000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture an accepted beam
        logic look;   // cosine lookup, window check, range scaling
        logic mul;    // closing speed multiply
        logic fin;    // limit multiply, compare, state update, result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;      // the beam in flight closes the scan
        logic out_free;  // the result register can take a new result
    } sts_t;

endpackage

`default_nettype wire

### rtl/core/teb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module teb_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire teb_pkg::sts_t sts,
    output teb_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_CMP  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: state_next = ST_MUL;
            ST_MUL:  state_next = ST_CMP;
            ST_CMP: begin
                // A closing beam waits here until the result register is free.
                if (!sts.last || sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign cmd.load = (state_reg == ST_IDLE) && s_valid;
    assign cmd.look = (state_reg == ST_LOOK);
    assign cmd.mul  = (state_reg == ST_MUL);
    assign cmd.fin  = (state_reg == ST_CMP) && (!sts.last || sts.out_free);

endmodule

`default_nettype wire

### rtl/core/teb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module teb_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire teb_pkg::cmd_t                       cmd,
    output teb_pkg::sts_t                            sts,
    input  wire logic                                cfg_we,
    input  wire logic [teb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [teb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [15:0]                         range_mm,
    input  wire logic                                range_valid,
    input  wire logic signed [15:0]                  speed_mm_s,
    input  wire logic                                last_beam,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output logic                                     brake
);

    localparam int COS_W_F = teb_pkg::Q14_SHIFT;

    // Configuration registers.
    logic [15:0] angle_start_reg;
    logic [11:0] angle_step_reg;
    logic [15:0] window_low_reg;
    logic [15:0] window_high_reg;
    logic [15:0] range_floor_reg;
    logic [15:0] ttc_limit_reg;

    // Scan state.
    logic [15:0] running_angle_reg;
    logic [15:0] running_angle_next;
    logic        danger_seen_reg;
    logic        danger_seen_next;

    // Beam in flight.
    logic [15:0]        angle_reg;
    logic [15:0]        range_reg;
    logic               valid_reg;
    logic signed [15:0] speed_reg;
    logic               last_reg;

    // Intermediate results.
    logic signed [15:0] cos_reg;
    logic               elig_reg;
    logic [25:0]        range_ms_reg;
    logic signed [30:0] closing_reg;

    // Result register.
    logic res_valid_reg;
    logic brake_reg;

    logic                         start_write;
    logic [1:0]                   quad;
    logic [COS_W_F-1:0]           frac;
    logic [teb_pkg::COS_PROD_W-1:0] kprod;
    logic [teb_pkg::COS_IDX_W-1:0]  k;
    logic [teb_pkg::COS_IDX_W-1:0]  tidx;
    logic [14:0]                  tval;
    logic                         cos_neg;
    logic signed [15:0]           cos_val;
    logic                         elig;
    logic                         closing_pos;
    logic [45:0]                  lhs;
    logic [45:0]                  rhs;
    logic                         danger;
    logic                         scan_hit;

    assign start_write = cfg_we && (cfg_index == teb_pkg::REG_ANGLE_START);

    // Cosine lookup: quadrant from the top two bits, table index from the rest.
    assign quad  = angle_reg[15:14];
    assign frac  = angle_reg[COS_W_F-1:0];
    assign kprod = teb_pkg::COS_PROD_W'(frac) * teb_pkg::COS_PROD_W'(teb_pkg::COS_ENTRIES)
                 + teb_pkg::COS_PROD_W'(1 << (COS_W_F - 1));
    assign k     = kprod[COS_W_F +: teb_pkg::COS_IDX_W];
    assign tidx  = quad[0] ? (teb_pkg::COS_IDX_W'(teb_pkg::COS_ENTRIES) - k) : k;
    assign tval  = teb_pkg::COS_TAB[tidx];
    assign cos_neg = (quad == 2'd1) || (quad == 2'd2);
    assign cos_val = cos_neg ? -$signed({1'b0, tval}) : $signed({1'b0, tval});

    assign elig = valid_reg && (range_reg >= range_floor_reg)
               && ($signed(angle_reg) >= $signed(window_low_reg))
               && ($signed(angle_reg) <= $signed(window_high_reg));

    // range * 1000 * 16384 <= limit * closing, with closing positive.
    assign closing_pos = !closing_reg[30] && (closing_reg != 31'sd0);
    assign lhs    = {6'd0, range_ms_reg, 14'd0};
    assign rhs    = 46'(ttc_limit_reg) * 46'(closing_reg[29:0]);
    assign danger = elig_reg && closing_pos && (lhs <= rhs);
    assign scan_hit = danger_seen_reg || danger;

    always_comb begin
        running_angle_next = running_angle_reg;
        danger_seen_next   = danger_seen_reg;
        if (cmd.fin) begin
            if (last_reg) begin
                running_angle_next = angle_start_reg;
                danger_seen_next   = 1'b0;
            end else begin
                running_angle_next = angle_reg + 16'(angle_step_reg);
                danger_seen_next   = scan_hit;
            end
        end
        if (start_write) begin
            running_angle_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_start_reg   <= teb_pkg::ANGLE_START_RST;
            angle_step_reg    <= teb_pkg::ANGLE_STEP_RST;
            window_low_reg    <= teb_pkg::WINDOW_LOW_RST;
            window_high_reg   <= teb_pkg::WINDOW_HIGH_RST;
            range_floor_reg   <= teb_pkg::RANGE_FLOOR_RST;
            ttc_limit_reg     <= teb_pkg::TTC_LIMIT_RST;
            running_angle_reg <= teb_pkg::ANGLE_START_RST;
            danger_seen_reg   <= 1'b0;
            res_valid_reg     <= 1'b0;
        end else begin
            running_angle_reg <= running_angle_next;
            danger_seen_reg   <= danger_seen_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    teb_pkg::REG_ANGLE_START: angle_start_reg <= cfg_data;
                    teb_pkg::REG_ANGLE_STEP:  angle_step_reg  <= cfg_data[11:0];
                    teb_pkg::REG_WINDOW_LOW:  window_low_reg  <= cfg_data;
                    teb_pkg::REG_WINDOW_HIGH: window_high_reg <= cfg_data;
                    teb_pkg::REG_RANGE_FLOOR: range_floor_reg <= cfg_data;
                    teb_pkg::REG_TTC_LIMIT:   ttc_limit_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.fin && last_reg) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            // A start angle written in the same cycle applies to this beam.
            angle_reg <= start_write ? cfg_data : running_angle_reg;
            range_reg <= range_mm;
            valid_reg <= range_valid;
            speed_reg <= speed_mm_s;
            last_reg  <= last_beam;
        end
        if (cmd.look) begin
            cos_reg      <= cos_val;
            elig_reg     <= elig;
            range_ms_reg <= 26'(range_reg) * 26'(teb_pkg::MS_PER_S);
        end
        if (cmd.mul) begin
            closing_reg <= 31'(cos_reg) * 31'(speed_reg);
        end
        if (cmd.fin && last_reg) begin
            brake_reg <= scan_hit;
        end
    end

    assign sts.last     = last_reg;
    assign sts.out_free = !res_valid_reg || res_ready;
    assign res_valid    = res_valid_reg;
    assign brake        = brake_reg;

endmodule

`default_nettype wire

### rtl/core/ttc_emergency_brake_check.sv
// Time-to-collision emergency brake check, one lidar beam per transaction.
// The slave stream carries one beam: tdata holds range_mm (bits 15:0) and
// speed_mm_s (bits 31:16), tuser flags a real range and tlast marks the
// last beam of a scan. The master stream carries one transaction per scan,
// sent after the last beam: tdata bit 0 is the brake flag, the rest zero.
// Each beam goes through these steps in order: accepting it, the cosine
// lookup and window check, the closing speed multiply, and the limit
// multiply, compare and scan update. They run one after the other in a
// single datapath, so a new beam is taken only once the previous one is
// done. The brake result is registered on the master side when a last
// beam finishes its final step. The result sits in an output register;
// while it waits, the next scan's beams are still accepted, and only a
// following last beam holds in its final step until the register is free.
// The configuration port writes one register per cycle with cfg_we high;
// writes are meant for idle periods. Writing the start angle also restarts
// the running beam angle. Synchronous reset, active low, loads the
// register defaults, clears the scan state and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

`include "ttc_emergency_brake_check_macros.svh"

module ttc_emergency_brake_check (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port.
    input  wire logic                           cfg_we,
    input  wire logic [teb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [teb_pkg::CFG_DATA_W-1:0] cfg_data,
    // Beam stream.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [31:0]                    s_axis_tdata,  // range_mm, speed_mm_s
    input  wire logic [0:0]                     s_axis_tuser,  // range_valid
    input  wire logic                           s_axis_tlast,
    // Brake result stream.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [7:0]                          m_axis_tdata   // brake, zero padding
);

    teb_pkg::cmd_t cmd;
    teb_pkg::sts_t sts;
    logic          brake;

    // The controller sequences the four steps of a beam.
    teb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the registers, the scan state and the arithmetic.
    teb_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .range_mm    (s_axis_tdata[15:0]),
        .range_valid (s_axis_tuser[0]),
        .speed_mm_s  (s_axis_tdata[31:16]),
        .last_beam   (s_axis_tlast),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .brake       (brake)
    );

    assign m_axis_tdata = {7'd0, brake};

    // A result is never written over one that is still waiting.
    `TEB_ASSERT_NEVER(a_no_result_overrun, aclk, aresetn, cmd.fin && sts.last && m_axis_tvalid && !m_axis_tready, "brake result overwritten while stalled")

    // An accepted beam moves straight on to its lookup step.
    `TEB_ASSERT(a_accept_starts_lookup, aclk, aresetn, s_axis_tvalid && s_axis_tready |=> cmd.look, "accepted beam did not enter lookup")

    // No beam is taken while another one is in flight.
    `TEB_ASSERT_NEVER(a_ready_only_idle, aclk, aresetn, s_axis_tready && (cmd.look || cmd.mul || cmd.fin), "beam accepted while busy")

    // A new result only follows the final step of a last beam.
    `TEB_ASSERT(a_result_from_last, aclk, aresetn, $rose(m_axis_tvalid) |-> $past(cmd.fin && sts.last), "result without a closing beam")

endmodule

`default_nettype wire

### tb/sv/ttc_emergency_brake_check_tb.sv
`timescale 1ns / 1ps

// Testbench for the time-to-collision emergency brake check.
// Beams go in on the slave stream, one transaction per beam, and the brake
// flag of each finished scan comes back on the master stream. A scoreboard
// predicts every brake flag from the same beams and register writes and
// checks the results in order.
module ttc_emergency_brake_check_tb;

    import teb_pkg::*;

    // Half the clock period in ns and the number of cycles a beam can still
    // be in flight after the last expected result has been seen.
    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 12;
    localparam int END_WAIT_MAX = 4000;

    // Register indexes past the end of the register map; the block must
    // ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // Every input of the block starts at a known value.
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;  // range_mm, speed_mm_s
    logic [0:0]            s_axis_tuser  = '0;  // range_valid
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // brake, zero padding

    // Largest idle gap, in cycles, that the beam source and the result sink
    // draw before each transaction. Zero gives stretches at full rate.
    int src_idle_max = 18;
    int snk_idle_max = 18;

    ttc_emergency_brake_check i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // The scoreboard keeps its own copy of the registers and the scan state.
    // Each accepted beam updates that state; each last beam queues the brake
    // flag the block must send for the scan.
    class brake_scoreboard;
        logic [15:0] angle_start;
        logic [11:0] angle_step;
        logic [15:0] window_low;
        logic [15:0] window_high;
        logic [15:0] range_floor;
        logic [15:0] ttc_limit;
        logic [15:0] beam_angle;
        bit          scan_danger;
        int          cos_q14_tab [0:COS_ENTRIES];
        bit          brake_queue [$];
        int          fail_count;

        // Register defaults, and the quarter-wave cosine table: an eight-term
        // Taylor series in Q30, clamped to [0, 1.0] and rounded to Q14.
        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned mag;
            longint          sum;
            angle_start = ANGLE_START_RST;
            angle_step  = ANGLE_STEP_RST;
            window_low  = WINDOW_LOW_RST;
            window_high = WINDOW_HIGH_RST;
            range_floor = RANGE_FLOOR_RST;
            ttc_limit   = TTC_LIMIT_RST;
            beam_angle  = ANGLE_START_RST;
            scan_danger = 1'b0;
            fail_count  = 0;
            for (int k = 0; k <= COS_ENTRIES; k++) begin
                x   = (64'(k) * PI_HALF_Q30) / 64'(COS_ENTRIES);
                x2  = (x * x) >> 30;
                mag = 64'd1 << 30;
                sum = 64'sd1 <<< 30;
                for (int n = 1; n <= 7; n++) begin
                    mag = ((mag * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                    if (n % 2 == 1) begin
                        sum = sum - longint'(mag);
                    end else begin
                        sum = sum + longint'(mag);
                    end
                end
                if (sum < 0) begin
                    sum = 0;
                end
                if (sum > (64'sd1 <<< 30)) begin
                    sum = 64'sd1 <<< 30;
                end
                cos_q14_tab[k] = int'((sum + 64'sd32768) >>> 16);
            end
        endfunction

        // Cosine of a binary angle in Q1.14, folded from the first quadrant.
        function int cosine(logic [15:0] a);
            int k;
            k = (int'(a[13:0]) * COS_ENTRIES + 8192) >>> 14;
            if (k > COS_ENTRIES) begin
                k = COS_ENTRIES;
            end
            case (a[15:14])
                2'd0:    return cos_q14_tab[k];
                2'd1:    return -cos_q14_tab[COS_ENTRIES - k];
                2'd2:    return -cos_q14_tab[k];
                default: return cos_q14_tab[COS_ENTRIES - k];
            endcase
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
            case (idx)
                REG_ANGLE_START: begin
                    // A new start angle also restarts the running angle.
                    angle_start = value;
                    beam_angle  = value;
                end
                REG_ANGLE_STEP:  angle_step  = value[11:0];
                REG_WINDOW_LOW:  window_low  = value;
                REG_WINDOW_HIGH: window_high = value;
                REG_RANGE_FLOOR: range_floor = value;
                REG_TTC_LIMIT:   ttc_limit   = value;
                default: ;
            endcase
        endfunction

        // Called for every accepted beam transaction.
        function void note_beam(logic [15:0] range_mm, bit range_valid,
                                logic [15:0] speed_mm_s, bit last_beam);
            longint closing;
            longint lhs;
            longint rhs;
            bit     danger;
            danger = 1'b0;
            if (range_valid && range_mm >= range_floor &&
                $signed(beam_angle) >= $signed(window_low) &&
                $signed(beam_angle) <= $signed(window_high)) begin
                closing = longint'(cosine(beam_angle)) * longint'($signed(speed_mm_s));
                if (closing > 0) begin
                    // range * 1000 ms/s * 2^14 <= limit * closing speed in Q14.
                    lhs    = longint'(range_mm) * 64'sd16384000;
                    rhs    = longint'(ttc_limit) * closing;
                    danger = (lhs <= rhs);
                end
            end
            scan_danger = scan_danger | danger;
            beam_angle  = beam_angle + 16'(angle_step);
            if (last_beam) begin
                brake_queue = {brake_queue, scan_danger};
                scan_danger = 1'b0;
                beam_angle  = angle_start;
            end
        endfunction

        function void note_failure(string what, logic [7:0] want, logic [7:0] got);
            fail_count++;
            if (fail_count <= 10) begin
                $display("%0t ns: %s: expected %02h, got %02h", $time, what, want, got);
            end
        endfunction

        // Called for every accepted result transaction.
        function void check_brake(logic [7:0] tdata);
            logic [7:0] want;
            if (brake_queue.size() == 0) begin
                note_failure("brake result with no scan pending", 8'hxx, tdata);
                return;
            end
            want = {7'd0, brake_queue.pop_front()};
            if (tdata !== want) begin
                note_failure("brake flag mismatch", want, tdata);
            end
        endfunction

        function int pending();
            return brake_queue.size();
        endfunction
    endclass

    brake_scoreboard sb = new();

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Offers one beam after a random gap and holds it until the block takes
    // it. When the gap is zero, tvalid simply stays high from the previous
    // beam, so it is never lowered and raised in the same step.
    task automatic send_beam(logic [15:0] range_mm, bit range_valid,
                             logic [15:0] speed_mm_s, bit last_beam);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {speed_mm_s, range_mm};
        s_axis_tuser  <= range_valid;
        s_axis_tlast  <= last_beam;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_beam(range_mm, range_valid, speed_mm_s, last_beam);
    endtask

    // Stops the beam stream and waits until every brake flag has come back,
    // then lets a beam that makes no result finish its steps in the block.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One register write; the caller lowers cfg_we after the last of a run.
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    // Writes all six registers once the block is idle. The step register
    // gets random bits above its width, which the block must drop.
    task automatic program_regs(logic [15:0] start, logic [11:0] step,
                                logic [15:0] win_lo, logic [15:0] win_hi,
                                logic [15:0] floor_mm, logic [15:0] limit_ms);
        settle();
        set_reg(REG_ANGLE_START, start);
        set_reg(REG_ANGLE_STEP, {4'($urandom), step});
        set_reg(REG_WINDOW_LOW, win_lo);
        set_reg(REG_WINDOW_HIGH, win_hi);
        set_reg(REG_RANGE_FLOOR, floor_mm);
        set_reg(REG_TTC_LIMIT, limit_ms);
        cfg_we <= 1'b0;
    endtask

    // Result sink: a random stall before each brake transaction.
    initial begin
        int gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = $urandom_range(0, snk_idle_max);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            sb.check_brake(m_axis_tdata);
        end
    end

    // Beam source and run control.
    initial begin
        logic [15:0] rng;
        logic [15:0] spd;
        bit          vld;
        bit          lst;
        logic [15:0] st;
        logic [11:0] stp;
        logic [15:0] wl;
        logic [15:0] wh;
        logic [15:0] fl;
        logic [15:0] lim;
        int          len;
        int          left;
        int          waited;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beams at the reset settings: start angle 0, one degree
        // per beam, a window of +/-30 degrees and a one second limit.
        send_beam(16'd0, 1'b1, 16'h7FFF, 1'b1);      // zero range, full speed
        send_beam(16'hFFFF, 1'b1, 16'h8000, 1'b1);   // far away, reversing
        send_beam(16'd0, 1'b0, 16'h7FFF, 1'b1);      // range not a number
        // A danger in the middle of a scan must carry to the last beam.
        send_beam(16'hFFFF, 1'b1, 16'h7FFF, 1'b0);
        send_beam(16'd100, 1'b1, 16'd20000, 1'b0);
        send_beam(16'hFFFF, 1'b0, 16'd0, 1'b1);
        // The flag is cleared for the next scan; standing still is safe.
        send_beam(16'd5000, 1'b1, 16'd0, 1'b1);

        // Zero limit: only zero range with some closing speed brakes.
        program_regs(16'd0, 12'd0, 16'h8000, 16'h7FFF, 16'd0, 16'd0);
        send_beam(16'd0, 1'b1, 16'd1, 1'b1);
        send_beam(16'd1, 1'b1, 16'h7FFF, 1'b1);

        // Writes past the register map leave every setting alone.
        settle();
        set_reg(REG_SPARE_6, 16'hFFFF);
        set_reg(REG_SPARE_7, 16'h1234);
        cfg_we <= 1'b0;
        send_beam(16'd0, 1'b1, 16'd1, 1'b1);

        // A beam at a right angle has no closing speed at all.
        program_regs(16'h4000, 12'hFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        send_beam(16'hFFFF, 1'b1, 16'h7FFF, 1'b1);

        // Looking backwards while reversing at full speed closes in; the
        // highest floor drops everything below the largest range.
        program_regs(16'h8000, 12'hFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        send_beam(16'hFFFF, 1'b1, 16'h8000, 1'b1);
        send_beam(16'hFFFE, 1'b1, 16'h8000, 1'b1);

        // A new start angle in the middle of a scan: the pending danger
        // survives and the next beam uses the new angle.
        program_regs(16'h8000, 12'd182, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF);
        send_beam(16'd0, 1'b1, 16'h8000, 1'b0);
        settle();
        set_reg(REG_ANGLE_START, 16'h7FFF);
        cfg_we <= 1'b0;
        send_beam(16'hFFFF, 1'b1, 16'd0, 1'b1);

        // An empty window, low above high, lets no beam count.
        program_regs(16'd0, 12'd182, 16'd100, 16'hFF9C, 16'd0, 16'hFFFF);
        send_beam(16'd0, 1'b1, 16'h7FFF, 1'b1);

        // Window edges: both ends count; the scan then closes one step past the top.
        program_regs(16'hEAAB, 12'd1, 16'hEAAB, 16'hEAAC, 16'd0, 16'hFFFF);
        send_beam(16'd0, 1'b1, 16'h7FFF, 1'b1);
        send_beam(16'hFFFF, 1'b1, 16'd0, 1'b0);
        send_beam(16'd0, 1'b1, 16'h7FFF, 1'b0);
        send_beam(16'd0, 1'b1, 16'h7FFF, 1'b1);

        // Random phases. Each one programs a fresh setting, often at the
        // extremes, and sends scans of random length with random beams.
        // A few tlast marks are flipped to break scans apart or merge them.
        for (int phase = 0; phase < 9; phase++) begin
            case ($urandom_range(0, 3))
                0:       st = 16'h8000;
                1:       st = 16'h7FFF;
                2:       st = 16'd0;
                default: st = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       stp = 12'd0;
                1:       stp = 12'hFFF;
                2:       stp = 12'd182;
                default: stp = 12'($urandom_range(0, 1000));
            endcase
            case ($urandom_range(0, 4))
                0: begin
                    wl = 16'h8000;
                    wh = 16'h7FFF;
                end
                1: begin
                    wl = 16'($urandom);
                    wh = wl - 16'($urandom_range(1, 3000));
                end
                2: begin
                    wl = st - 16'($urandom_range(0, 4000));
                    wh = st + 16'($urandom_range(0, 8000));
                end
                default: begin
                    wl = WINDOW_LOW_RST;
                    wh = WINDOW_HIGH_RST;
                end
            endcase
            case ($urandom_range(0, 5))
                0:       fl = 16'hFFFF;
                1:       fl = 16'($urandom_range(0, 3000));
                default: fl = 16'd0;
            endcase
            case ($urandom_range(0, 3))
                0:       lim = 16'd0;
                1:       lim = 16'hFFFF;
                2:       lim = 16'd1000;
                default: lim = 16'($urandom_range(0, 5000));
            endcase
            program_regs(st, stp, wl, wh, fl, lim);
            src_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
            snk_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 18;

            left = 92;
            while (left > 0) begin
                len = $urandom_range(1, 24);
                if (len > left) begin
                    len = left;
                end
                for (int i = 0; i < len; i++) begin
                    // Ranges lean towards the distances where braking is
                    // decided, speeds towards driving forward.
                    case ($urandom_range(0, 4))
                        0, 1:    rng = 16'($urandom_range(0, 3000));
                        2:       rng = 16'($urandom_range(0, 20000));
                        default: rng = 16'($urandom);
                    endcase
                    case ($urandom_range(0, 4))
                        0, 1, 2: spd = 16'($urandom_range(2000, 32767));
                        3:       spd = 16'($urandom_range(32768, 65535));
                        default: spd = 16'($urandom);
                    endcase
                    vld = ($urandom_range(0, 9) != 0);
                    lst = (i == len - 1);
                    if ($urandom_range(0, 99) < 6) begin
                        lst = !lst;
                    end
                    send_beam(rng, vld, spd, lst);
                end
                left -= len;
            end
        end

        // Wait for the remaining brake flags, with a limit, then give any
        // beam still in the block time to finish.
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < END_WAIT_MAX) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.note_failure("scan never got its brake result", 8'hxx, 8'hxx);
        end

        if (sb.fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
